@@ hw/rtl/mte_pkg.sv @@
// mte_pkg: shared types, constants and request codes for the
// multi-turn encoder in-position tracker; no dependencies
package mte_pkg;

    localparam int MOTOR_COUNT  = 8;
    localparam int ENCODER_BITS = 13;
    localparam int HALF_TURN    = 1 << (ENCODER_BITS - 1);
    localparam int FULL_TURN    = 1 << ENCODER_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_FEEDBACK = 3'd0,
        REQ_TICK     = 3'd1,
        REQ_SET_ABS  = 3'd2,
        REQ_SET_REL  = 3'd3,
        REQ_SPEED    = 3'd4,
        REQ_ENABLE   = 3'd5,
        REQ_QUERY    = 3'd6
    } req_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_WINDOW = 2'd0,
        CFG_SPEED_WINDOW = 2'd1,
        CFG_SETTLE_TICKS = 2'd2
    } cfg_reg_t;

    localparam logic [15:0] ANGLE_WINDOW_RESET = 16'd1138;
    localparam logic [14:0] SPEED_WINDOW_RESET = 15'd500;
    localparam logic [8:0]  SETTLE_TICKS_RESET = 9'd500;

    // live configuration values
    typedef struct packed {
        logic [15:0] angle_window;
        logic [14:0] speed_window;
        logic [8:0]  settle_ticks;
    } cfg_t;

    // registered command word as seen by every motor lane
    typedef struct packed {
        logic [2:0]               req;
        logic [ENCODER_BITS-1:0]  angle;
        logic signed [15:0]       speed;
        logic [31:0]              target;
        logic                     enable;
    } cmd_t;

    // post-update view of one motor, for the result word
    typedef struct packed {
        logic [31:0] total;
        logic        event_flag;
        logic        level;
        logic        tracking;
    } view_t;

endpackage

@@ hw/rtl/mte_if.sv @@
// mte_cmd_if and mte_res_if: valid/ready channels for command and result words
// depends on mte_pkg for the encoder width
interface mte_cmd_if;
    import mte_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [2:0]              req_type;
    logic [2:0]              motor_index;
    logic [ENCODER_BITS-1:0] shaft_angle;
    logic signed [15:0]      shaft_speed;
    logic signed [31:0]      target_value;
    logic                    enable_bit;

    modport source (output valid, req_type, motor_index, shaft_angle, shaft_speed,
                    target_value, enable_bit, input ready);
    modport sink   (input valid, req_type, motor_index, shaft_angle, shaft_speed,
                    target_value, enable_bit, output ready);
endinterface

interface mte_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] total_angle_ticks;
    logic               arrived_event;
    logic               arrived_level;
    logic               tracking_valid;

    modport source (output valid, total_angle_ticks, arrived_event, arrived_level,
                    tracking_valid, input ready);
    modport sink   (input valid, total_angle_ticks, arrived_event, arrived_level,
                    tracking_valid, output ready);
endinterface

@@ hw/rtl/multiturn_encoder_inposition_tracker.sv @@
// multiturn_encoder_inposition_tracker: top level with command and result stages
// depends on mte_pkg, mte_if, mte_cfg_regs and mte_motor_lane
//
// Usage
//   cmd: one event word per motor (feedback frame, tick, set target absolute
//        or relative, speed mode, enable, arrival query), valid/ready.
//   res: exactly one result word per event: unwrapped angle of the addressed
//        motor, query arrival event, arrival level and tracking flag.
//   cfg: write port for the angle window, speed window and settle count;
//        write only while no word is in flight.
// Timing
//   a word is registered in the command stage on acceptance, its result in
//   the result stage when it advances; one word per cycle is sustained while
//   res is not stalled, set by the per-motor state read-modify-write.
//   a tick updates all motors at once in parallel lanes.
// Reset
//   all motors untracked, speed mode, enabled, no arrival; configuration
//   returns to its defaults; both stages empty.
// Stall
//   while res is stalled the held result stays and one more word is taken
//   into the command stage, then cmd.ready drops; no word is lost.
module multiturn_encoder_inposition_tracker
    import mte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mte_cmd_if.sink               cmd,
    mte_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg;
    logic        cmd_valid_reg;
    cmd_t        cmd_reg;
    logic [2:0]  idx_reg;
    logic        res_valid_reg;
    view_t       res_reg;
    logic        advance;
    logic        in_range;
    view_t       views [MOTOR_COUNT];
    view_t       sel_view;

    mte_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake between the two stages
    assign advance   = cmd_valid_reg && (!res_valid_reg || res.ready);
    assign cmd.ready = !cmd_valid_reg || advance;

    // command stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd.ready)
            cmd_valid_reg <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg.req    <= cmd.req_type;
            cmd_reg.angle  <= cmd.shaft_angle;
            cmd_reg.speed  <= cmd.shaft_speed;
            cmd_reg.target <= cmd.target_value;
            cmd_reg.enable <= cmd.enable_bit;
            idx_reg        <= cmd.motor_index;
        end
    end

    assign in_range = ({1'b0, idx_reg} < 4'(MOTOR_COUNT));

    // one lane per motor
    for (genvar i = 0; i < MOTOR_COUNT; i++)
    begin : g_lane
        mte_motor_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .hit     (in_range && (idx_reg == 3'(i))),
            .cmd     (cmd_reg),
            .cfg     (cfg),
            .view    (views[i])
        );
    end

    // pick the addressed motor, all zero when out of range
    assign sel_view = in_range ? views[idx_reg] : '0;

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= sel_view;
    end

    assign res.valid             = res_valid_reg;
    assign res.total_angle_ticks = $signed(res_reg.total);
    assign res.arrived_event     = res_reg.event_flag;
    assign res.arrived_level     = res_reg.level;
    assign res.tracking_valid    = res_reg.tracking;

endmodule

@@ hw/rtl/mte_cfg_regs.sv @@
// mte_cfg_regs: window and settle configuration registers
// depends on mte_pkg
module mte_cfg_regs
    import mte_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // register write, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_window <= ANGLE_WINDOW_RESET;
            cfg_reg.speed_window <= SPEED_WINDOW_RESET;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ANGLE_WINDOW: cfg_reg.angle_window <= cfg_data;
                CFG_SPEED_WINDOW: cfg_reg.speed_window <= cfg_data[14:0];
                CFG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/mte_motor_lane.sv @@
// mte_motor_lane: state and next-state update of one motor
// (unwrapped angle, target, settle counter, arrival latch); depends on mte_pkg
module mte_motor_lane
    import mte_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  advance,
    input  logic  hit,
    input  cmd_t  cmd,
    input  cfg_t  cfg,
    output view_t view
);

    // motor state
    logic                    tracking_reg, tracking_next;
    logic [ENCODER_BITS-1:0] angle_reg, angle_next;
    logic [31:0]             total_reg, total_next;
    logic signed [15:0]      speed_reg, speed_next;
    logic [31:0]             target_reg, target_next;
    logic                    pos_mode_reg, pos_mode_next;
    logic                    enabled_reg, enabled_next;
    logic [8:0]              settle_reg, settle_next;
    logic                    latch_reg, latch_next;
    logic                    ack_reg, ack_next;
    logic                    event_flag;

    // settle window checks against the stored state
    logic signed [32:0]       pos_err;
    logic signed [32:0]       angle_win;
    logic signed [16:0]       speed_ext;
    logic signed [16:0]       speed_win;
    logic                     in_window;
    logic signed [ENCODER_BITS:0] delta;
    logic [31:0]              turn_adj;

    assign pos_err   = $signed({target_reg[31], target_reg}) - $signed({total_reg[31], total_reg});
    assign angle_win = $signed({17'd0, cfg.angle_window});
    assign speed_ext = $signed({speed_reg[15], speed_reg});
    assign speed_win = $signed({2'd0, cfg.speed_window});
    assign in_window = (pos_err < angle_win) && (pos_err > -angle_win)
                    && (speed_ext < speed_win) && (speed_ext > -speed_win);

    // angle step since the last frame, with a full turn folded in on wrap
    assign delta = $signed({1'b0, cmd.angle}) - $signed({1'b0, angle_reg});
    always_comb
    begin
        priority if (delta > $signed((ENCODER_BITS + 1)'(HALF_TURN)))
            turn_adj = 32'(delta) - 32'(FULL_TURN);
        else if (delta < -$signed((ENCODER_BITS + 1)'(HALF_TURN)))
            turn_adj = 32'(delta) + 32'(FULL_TURN);
        else
            turn_adj = 32'(delta);
    end

    // next state for the current command word
    always_comb
    begin
        tracking_next = tracking_reg;
        angle_next    = angle_reg;
        total_next    = total_reg;
        speed_next    = speed_reg;
        target_next   = target_reg;
        pos_mode_next = pos_mode_reg;
        enabled_next  = enabled_reg;
        settle_next   = settle_reg;
        latch_next    = latch_reg;
        ack_next      = ack_reg;
        event_flag    = 1'b0;

        if (cmd.req == REQ_TICK)
        begin
            if (!enabled_reg || !tracking_reg)
            begin
                settle_next = '0;
                latch_next  = 1'b0;
                ack_next    = 1'b0;
            end
            else if (pos_mode_reg)
            begin
                if (in_window)
                begin
                    if (settle_reg < cfg.settle_ticks)
                        settle_next = settle_reg + 9'd1;
                    else
                        latch_next = 1'b1;
                end
                else
                begin
                    settle_next = '0;
                    latch_next  = 1'b0;
                    ack_next    = 1'b0;
                end
            end
        end
        else if (hit)
        begin
            unique case (cmd.req)
                REQ_FEEDBACK:
                begin
                    // first frame fixes the zero, so the total starts at 0
                    if (!tracking_reg)
                    begin
                        tracking_next = 1'b1;
                        total_next    = '0;
                    end
                    else
                        total_next = total_reg + turn_adj;
                    angle_next = cmd.angle;
                    speed_next = cmd.speed;
                end
                REQ_SET_ABS:
                begin
                    latch_next    = 1'b0;
                    pos_mode_next = 1'b1;
                    target_next   = cmd.target;
                end
                REQ_SET_REL:
                begin
                    latch_next    = 1'b0;
                    pos_mode_next = 1'b1;
                    target_next   = total_reg + cmd.target;
                end
                REQ_SPEED:
                begin
                    latch_next    = 1'b0;
                    pos_mode_next = 1'b0;
                end
                REQ_ENABLE:
                    enabled_next = cmd.enable;
                REQ_QUERY:
                begin
                    if (latch_reg && !ack_reg)
                    begin
                        ack_next   = 1'b1;
                        event_flag = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers, updated when the word moves to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= 1'b0;
            angle_reg    <= '0;
            total_reg    <= '0;
            speed_reg    <= '0;
            target_reg   <= '0;
            pos_mode_reg <= 1'b0;
            enabled_reg  <= 1'b1;
            settle_reg   <= '0;
            latch_reg    <= 1'b0;
            ack_reg      <= 1'b0;
        end
        else if (advance)
        begin
            tracking_reg <= tracking_next;
            angle_reg    <= angle_next;
            total_reg    <= total_next;
            speed_reg    <= speed_next;
            target_reg   <= target_next;
            pos_mode_reg <= pos_mode_next;
            enabled_reg  <= enabled_next;
            settle_reg   <= settle_next;
            latch_reg    <= latch_next;
            ack_reg      <= ack_next;
        end
    end

    // view after the update, total stays 0 until tracking
    assign view.total      = total_next;
    assign view.event_flag = event_flag;
    assign view.level      = latch_next;
    assign view.tracking   = tracking_next;

endmodule
